// ===== rtl/rle_pkg.sv =====
// Package for the pixel run-length encoder.
// Holds the record type, register indexes and queue sizing shared by the core, queue, top level and testbench.
// No dependencies.
package rle_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_OUTPUT_LIMIT  = 2'd1;

  // Output queue sizing: room for two records per item plus slack.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Reset values of the configuration registers.
  localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd3;
  localparam logic [23:0] OUTPUT_LIMIT_RST  = 24'hFF_FFFF;

  // One encoded record.
  typedef struct packed {
    logic [7:0]  run_length;
    logic [31:0] run_pixel;
    logic        is_final;
    logic        overflow;
    logic [23:0] total_bytes;
  } rle_rec_t;

  // Records produced by one item, in order; rec_a goes first.
  typedef struct packed {
    logic [1:0] count;
    rle_rec_t   rec_a;
    rle_rec_t   rec_b;
  } rle_push_t;

endpackage

// ===== rtl/rle_core.sv =====
// Run tracking and byte accounting for the pixel run-length encoder.
// Updates the run state on each accepted item and builds up to two records.
// Depends on rle_pkg.
module rle_core
  import rle_pkg::*;
#(
  parameter int MAX_CHANNELS    = 4,
  parameter int MAX_RUN         = 255,
  parameter int BYTE_COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [31:0] pixel_value,
  input  logic        end_of_image,
  input  logic [2:0]  channel_count,
  input  logic [23:0] output_limit,
  output rle_push_t   push
);

  localparam int CW = ((BYTE_COUNT_BITS > 24) ? BYTE_COUNT_BITS : 24) + 2;

  // Run state.
  logic [31:0]                run_pixel_store;
  logic [7:0]                 run_count;
  logic [BYTE_COUNT_BITS-1:0] byte_count;
  logic                       overflow_flag;

  logic [31:0]                run_pixel_store_next;
  logic [7:0]                 run_count_next;
  logic [BYTE_COUNT_BITS-1:0] byte_count_next;
  logic                       overflow_flag_next;

  logic [3:0]    ch_eff;
  logic [31:0]   mask;
  logic [31:0]   pix;
  logic [CW-1:0] cost;
  logic [CW-1:0] bc_ext;
  logic [CW-1:0] sum1;
  logic [CW-1:0] sum2;
  logic [CW-1:0] limit_ext;
  logic [CW-1:0] count_max;
  logic          over1;
  logic          over2;
  logic          extend;
  logic          close;
  logic          ok1;
  logic          emit1;
  logic          ovf1;
  logic [CW-1:0] bc1;
  logic [CW-1:0] next2;
  logic          ok2;
  logic [7:0]    rc2;
  rle_rec_t      rec_close;
  rle_rec_t      rec_final;

  // Effective channel count, byte mask and record cost.
  always_comb begin
    if (channel_count == 3'd0) begin
      ch_eff = 4'd1;
    end else if ({1'b0, channel_count} > 4'(MAX_CHANNELS)) begin
      ch_eff = 4'(MAX_CHANNELS);
    end else begin
      ch_eff = {1'b0, channel_count};
    end
    for (int b = 0; b < 4; b++) begin
      mask[8*b +: 8] = (ch_eff > 4'(b)) ? 8'hFF : 8'h00;
    end
    pix  = pixel_value & mask;
    cost = CW'(ch_eff) + CW'(1);
  end

  // Run decision and both byte charges, computed side by side.
  always_comb begin
    bc_ext    = CW'(byte_count);
    limit_ext = CW'(output_limit);
    count_max = {{(CW-BYTE_COUNT_BITS){1'b0}}, {BYTE_COUNT_BITS{1'b1}}};
    sum1      = bc_ext + cost;
    sum2      = bc_ext + (cost << 1);

    extend = (run_count != 8'd0) && ((run_pixel_store & mask) == pix) &&
             (run_count < 8'(MAX_RUN));
    close  = !extend && (run_count != 8'd0);

    // Charge for the record that closes the old run.
    over1 = (sum1 > limit_ext) || (sum1 > count_max);
    ok1   = !overflow_flag && !over1;
    emit1 = close && ok1;
    ovf1  = overflow_flag || (close && over1);
    bc1   = emit1 ? sum1 : bc_ext;

    // Charge for the final record, on top of the first one.
    next2 = emit1 ? sum2 : sum1;
    over2 = (next2 > limit_ext) || (next2 > count_max);
    ok2   = !ovf1 && !over2;
    rc2   = extend ? (run_count + 8'd1) : 8'd1;

    rec_close.run_length  = run_count;
    rec_close.run_pixel   = run_pixel_store & mask;
    rec_close.is_final    = 1'b0;
    rec_close.overflow    = 1'b0;
    rec_close.total_bytes = 24'(bc1);

    // The run pixel of the open run always equals the masked input pixel.
    rec_final.is_final = 1'b1;
    if (ok2) begin
      rec_final.run_length  = rc2;
      rec_final.run_pixel   = pix;
      rec_final.overflow    = 1'b0;
      rec_final.total_bytes = 24'(next2);
    end else begin
      rec_final.run_length  = 8'd0;
      rec_final.run_pixel   = 32'd0;
      rec_final.overflow    = 1'b1;
      rec_final.total_bytes = 24'(bc1);
    end
  end

  // Records handed to the output queue for this item.
  always_comb begin
    push.rec_b = rec_final;
    if (!accept) begin
      push.count = 2'd0;
      push.rec_a = rec_close;
    end else if (emit1) begin
      push.count = end_of_image ? 2'd2 : 2'd1;
      push.rec_a = rec_close;
    end else begin
      push.count = end_of_image ? 2'd1 : 2'd0;
      push.rec_a = rec_final;
    end
  end

  // Next state: the final item of an image clears everything.
  always_comb begin
    if (end_of_image) begin
      run_pixel_store_next = 32'd0;
      run_count_next       = 8'd0;
      byte_count_next      = '0;
      overflow_flag_next   = 1'b0;
    end else begin
      run_pixel_store_next = extend ? run_pixel_store : pix;
      run_count_next       = rc2;
      byte_count_next      = BYTE_COUNT_BITS'(bc1);
      overflow_flag_next   = ovf1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_pixel_store <= 32'd0;
      run_count       <= 8'd0;
      byte_count      <= '0;
      overflow_flag   <= 1'b0;
    end else if (accept) begin
      run_pixel_store <= run_pixel_store_next;
      run_count       <= run_count_next;
      byte_count      <= byte_count_next;
      overflow_flag   <= overflow_flag_next;
    end
  end

endmodule

// ===== rtl/rle_queue.sv =====
// Output record queue for the pixel run-length encoder.
// Takes up to two records per cycle and hands out one per cycle while pop is high.
// Depends on rle_pkg.
module rle_queue
  import rle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rle_push_t push,
  input  logic      pop,
  output logic      room,
  output logic      not_empty,
  output rle_rec_t  head
);

  rle_rec_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] fill;
  logic [QCNT_W-1:0] fill_next;
  logic              do_pop;

  assign not_empty = (fill != '0);
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];
  // Room for the worst case of two records from the next item.
  assign room      = (fill <= QCNT_W'(QUEUE_DEPTH - 2));
  assign fill_next = fill + QCNT_W'(push.count) - QCNT_W'(do_pop);

  // Record storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.rec_a;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.rec_b;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      rd_ptr <= rd_ptr + QPTR_W'(do_pop);
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      fill   <= fill_next;
    end
  end

endmodule

// ===== rtl/pixel_rle_encoder.sv =====
// Top level of the pixel run-length encoder.
// Holds the configuration registers and joins rle_core to rle_queue.
// Depends on rle_pkg, rle_core and rle_queue.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------------------
//   in        in_valid / in_ready    pixel_value, end_of_image
//   out       out_valid / out_ready  run_length, run_pixel, is_final, overflow,
//                                    total_bytes
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while in_ready is high; its records are written
// into the output queue at the accepting edge, so the first record can be
// offered in the next cycle. An item yields zero, one or two records; the
// four-entry queue drains one record per cycle while out_ready is high, and
// in_ready drops while fewer than two entries are free. Reset is synchronous,
// clears the run state and the queue, and returns the registers to their
// reset values. cfg_ready is always high.
module pixel_rle_encoder
  import rle_pkg::*;
#(
  parameter int MAX_CHANNELS    = 4,
  parameter int MAX_RUN         = 255,
  parameter int BYTE_COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pixel_value,
  input  logic        end_of_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  run_length,
  output logic [31:0] run_pixel,
  output logic        is_final,
  output logic        overflow,
  output logic [23:0] total_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [2:0]  channel_count;
  logic [23:0] output_limit;
  logic        accept;
  rle_push_t   push;
  rle_rec_t    head;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
      output_limit  <= OUTPUT_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
        REG_OUTPUT_LIMIT:  output_limit  <= cfg_data;
        default:           ;
      endcase
    end
  end

  rle_core #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .MAX_RUN         (MAX_RUN),
    .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .pixel_value   (pixel_value),
    .end_of_image  (end_of_image),
    .channel_count (channel_count),
    .output_limit  (output_limit),
    .push          (push)
  );

  rle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_ready),
    .room      (in_ready),
    .not_empty (out_valid),
    .head      (head)
  );

  // Output fields come straight from the queue head.
  assign run_length  = head.run_length;
  assign run_pixel   = head.run_pixel;
  assign is_final    = head.is_final;
  assign overflow    = head.overflow;
  assign total_bytes = head.total_bytes;

endmodule

// ===== rtl/rle_checker.sv =====
// Port-level checks for the pixel run-length encoder.
// Watches only the top-level ports; bound to pixel_rle_encoder below.
// Depends on pixel_rle_encoder.
module rle_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  run_length,
  input logic [31:0] run_pixel,
  input logic        is_final,
  input logic        overflow,
  input logic [23:0] total_bytes
);

  // A stalled output item holds its run length, run pixel, final flag and byte total.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_length) &&
      $stable(run_pixel) && $stable(is_final) && $stable(total_bytes))
    else $error("output item changed while stalled");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Overflow is only reported on the final item of an image, with an empty run and zero pixel.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> is_final && run_length == 8'd0 && run_pixel == 32'd0)
    else $error("overflow item malformed");

  // An empty run appears only in an overflow report.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && run_length == 8'd0 |-> overflow)
    else $error("empty run without overflow");

endmodule

bind pixel_rle_encoder rle_checker u_rle_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .run_length  (run_length),
  .run_pixel   (run_pixel),
  .is_final    (is_final),
  .overflow    (overflow),
  .total_bytes (total_bytes)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pixel run-length encoder (pixel_rle_encoder).
// Predicts every record from accepted pixels and compares it with the output port.
// Depends on rle_pkg and the encoder RTL.
module tb_top;
  import rle_pkg::*;

  localparam int          ITEM_GOAL    = 1050;
  localparam int          RUN_MAX      = 255;
  localparam int          CHANNELS_MAX = 4;
  localparam logic [23:0] COUNT_MAX    = 24'hFF_FFFF;
  localparam logic [1:0]  REG_SPARE_2  = 2'd2;
  localparam logic [1:0]  REG_SPARE_3  = 2'd3;
  // Records enter the output queue at their item's accepting edge; settling cycles follow each drain.
  localparam int          SETTLE_CYCLES = 4;
  localparam int          DRAIN_LIMIT   = 5000;
  localparam int          TIMEOUT_NS    = 3_000_000;

  // Tracks the encoder state and holds the records it should produce, oldest first.
  class rle_record_board;
    logic [2:0]  channel_reg;
    logic [23:0] limit_reg;
    logic [31:0] run_pixel_q;
    int unsigned run_len_q;
    logic [23:0] bytes_q;
    bit          ovf_q;
    rle_rec_t    expected_records[$];
    int          errors;

    function new();
      channel_reg = CHANNEL_COUNT_RST;
      limit_reg   = OUTPUT_LIMIT_RST;
      run_pixel_q = '0;
      run_len_q   = 0;
      bytes_q     = '0;
      ovf_q       = 1'b0;
      errors      = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [23:0] data);
      case (idx)
        REG_CHANNEL_COUNT: channel_reg = data[2:0];
        REG_OUTPUT_LIMIT:  limit_reg = data;
        default: ;
      endcase
    endfunction

    // Channel counts of zero act as one, and large counts are clamped.
    function int active_channels();
      int c;
      c = int'(channel_reg);
      if (c == 0) c = 1;
      if (c > CHANNELS_MAX) c = CHANNELS_MAX;
      return c;
    endfunction

    function logic [31:0] mask_for(int ch);
      return 32'hFFFF_FFFF >> (8 * (4 - ch));
    endfunction

    // Accounts for one record; once the limit is passed everything is refused.
    function bit charge(int ch);
      longint next_bytes;
      if (ovf_q) return 1'b0;
      next_bytes = longint'(bytes_q) + 1 + ch;
      if (next_bytes > longint'(limit_reg) || next_bytes > longint'(COUNT_MAX)) begin
        ovf_q = 1'b1;
        return 1'b0;
      end
      bytes_q = next_bytes[23:0];
      return 1'b1;
    endfunction

    function void push_record(logic [7:0] len, logic [31:0] pix, logic fin, logic ovf);
      rle_rec_t r;
      r.run_length  = len;
      r.run_pixel   = pix;
      r.is_final    = fin;
      r.overflow    = ovf;
      r.total_bytes = bytes_q;
      expected_records.push_back(r);
    endfunction

    // Updates the run for one accepted pixel and queues the records it closes.
    function void take_pixel(logic [31:0] value, logic last);
      int          ch;
      logic [31:0] mask;
      logic [31:0] pix;
      ch   = active_channels();
      mask = mask_for(ch);
      pix  = value & mask;
      if (run_len_q != 0 && (run_pixel_q & mask) == pix && run_len_q < RUN_MAX) begin
        run_len_q++;
      end else begin
        if (run_len_q != 0 && charge(ch))
          push_record(8'(run_len_q), run_pixel_q & mask, 1'b0, 1'b0);
        run_pixel_q = pix;
        run_len_q   = 1;
      end
      // The last pixel flushes the open run and clears the image state.
      if (last) begin
        if (charge(ch)) push_record(8'(run_len_q), run_pixel_q & mask, 1'b1, 1'b0);
        else push_record(8'd0, 32'd0, 1'b1, 1'b1);
        run_pixel_q = '0;
        run_len_q   = 0;
        bytes_q     = '0;
        ovf_q       = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_record(rle_rec_t got);
      rle_rec_t want;
      if (expected_records.size() == 0) begin
        $error("record with none expected: run_length=%0d run_pixel=0x%08h total_bytes=%0d",
               got.run_length, got.run_pixel, got.total_bytes);
        errors++;
        return;
      end
      want = expected_records.pop_front();
      compare_field("run_length", 32'(want.run_length), 32'(got.run_length));
      compare_field("run_pixel", want.run_pixel, got.run_pixel);
      compare_field("is_final", 32'(want.is_final), 32'(got.is_final));
      compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
      compare_field("total_bytes", 32'(want.total_bytes), 32'(got.total_bytes));
    endfunction

    function int pending();
      return expected_records.size();
    endfunction
  endclass

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [31:0] pixel_value  = '0;
  logic        end_of_image = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  run_length;
  logic [31:0] run_pixel;
  logic        is_final;
  logic        overflow;
  logic [23:0] total_bytes;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = REG_CHANNEL_COUNT;
  logic [23:0] cfg_data     = '0;

  rle_record_board record_board;
  int              pixels_taken = 0;
  int              burst_left   = 0;

  pixel_rle_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_value  (pixel_value),
    .end_of_image (end_of_image),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .run_length   (run_length),
    .run_pixel    (run_pixel),
    .is_final     (is_final),
    .overflow     (overflow),
    .total_bytes  (total_bytes),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // Offers one pixel and waits for it to be taken; bursts end in a short gap.
  task automatic send_pixel(logic [31:0] value, logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    pixel_value  <= value;
    end_of_image <= last;
    do @(posedge clk); while (!in_ready);
    record_board.take_pixel(value, last);
    pixels_taken++;
    burst_left--;
  endtask

  task automatic write_register(logic [1:0] idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    record_board.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops the input and waits until every predicted record has come out or DRAIN_LIMIT is reached.
  task automatic drain_records();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (record_board.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Runs of repeated pixels from a small palette or random, with noise in the ignored bytes.
  task automatic send_random_phase(int span, bit with_long_run);
    int          sent;
    int          run_len;
    logic [31:0] base;
    logic [31:0] keep;
    logic [31:0] palette[4];
    logic        last;
    bit          long_now;
    sent = 0;
    foreach (palette[i]) palette[i] = $urandom;
    while (sent < span && pixels_taken < ITEM_GOAL) begin
      long_now = with_long_run && sent == 0;
      if (long_now) run_len = $urandom_range(RUN_MAX, RUN_MAX + 7);
      else if ($urandom_range(0, 7) == 0) run_len = 1;
      else run_len = $urandom_range(1, 6);
      base = $urandom_range(0, 1) ? palette[$urandom_range(0, 3)] : $urandom;
      keep = record_board.mask_for(record_board.active_channels());
      for (int k = 0; k < run_len && pixels_taken < ITEM_GOAL; k++) begin
        last = ($urandom_range(0, 63) == 0) ||
               (k == run_len - 1 && $urandom_range(0, 11) == 0);
        // The long run must reach the run limit, so no image ends inside it.
        if (long_now) last = 1'b0;
        send_pixel((base & keep) | ($urandom & ~keep), last);
        sent++;
      end
    end
  endtask

  // Picks a new setting for the next phase; some phases keep the old one.
  task automatic configure_random();
    logic [23:0] limit;
    case ($urandom_range(0, 3))
      0: limit = COUNT_MAX;
      1: limit = 24'($urandom_range(0, 40));
      2: limit = 24'($urandom_range(41, 600));
      default: limit = 24'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: begin
        write_register(REG_CHANNEL_COUNT,
                       24'(($urandom & 32'hFF_FFF8) | $urandom_range(0, 7)));
        write_register(REG_OUTPUT_LIMIT, limit);
      end
      1: write_register(REG_CHANNEL_COUNT,
                        24'(($urandom & 32'hFF_FFF8) | $urandom_range(1, 4)));
      2: write_register(REG_OUTPUT_LIMIT, limit);
      default: write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                              24'($urandom));
    endcase
  endtask

  // Output side: checks every taken record and stalls on its own pattern.
  initial begin
    rle_rec_t seen;
    int       mode;
    int       mode_left;
    int       hold_left;
    bit       held;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        seen.run_length  = run_length;
        seen.run_pixel   = run_pixel;
        seen.is_final    = is_final;
        seen.overflow    = overflow;
        seen.total_bytes = total_bytes;
        record_board.check_record(seen);
      end
      // One long hold-off while pixels keep coming, so the queue fills up.
      if (!held && pixels_taken >= 300) begin
        held      = 1'b1;
        hold_left = 150;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (mode_left % 5 != 0);
        endcase
      end
    end
  end

  // Stimulus: directed cases first, then random phases with new settings.
  initial begin
    int phase;
    record_board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: ignored top byte, run split by a new pixel, single-pixel image.
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b1);
    send_pixel(32'h1234_5678, 1'b1);
    drain_records();

    // Zero channel count acts as one; a zero limit overflows on the first record.
    write_register(REG_CHANNEL_COUNT, 24'h00_0000);
    write_register(REG_OUTPUT_LIMIT, 24'h00_0000);
    write_register(REG_SPARE_2, 24'hFF_FFFF);
    write_register(REG_SPARE_3, 24'h5A_5A5A);
    send_pixel(32'hFFFF_FFAB, 1'b0);
    send_pixel(32'h0000_00CD, 1'b0);
    send_pixel(32'h5555_55CD, 1'b1);
    drain_records();

    // Count above the maximum is clamped; two records fill the limit exactly.
    write_register(REG_CHANNEL_COUNT, 24'hFF_FFFF);
    write_register(REG_OUTPUT_LIMIT, 24'd10);
    send_pixel(32'h0000_0001, 1'b0);
    send_pixel(32'h0000_0002, 1'b0);
    send_pixel(32'h0000_0003, 1'b0);
    send_pixel(32'h0000_0003, 1'b1);
    drain_records();

    // Full pixels, then the channel count changes in the middle of an image.
    write_register(REG_CHANNEL_COUNT, 24'd4);
    write_register(REG_OUTPUT_LIMIT, COUNT_MAX);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'hA5A5_A5A5, 1'b0);
    send_pixel(32'hA5A5_A5A5, 1'b0);
    send_pixel(32'h5A5A_5A5A, 1'b0);
    drain_records();
    write_register(REG_CHANNEL_COUNT, 24'd2);
    send_pixel(32'h1234_5A5A, 1'b0);
    send_pixel(32'h0000_0000, 1'b1);

    phase = 0;
    while (pixels_taken < ITEM_GOAL) begin
      drain_records();
      configure_random();
      send_random_phase($urandom_range(40, 160), phase == 2 || phase == 6);
      phase++;
    end

    drain_records();
    if (record_board.pending() != 0) begin
      $error("%0d expected records never arrived", record_board.pending());
      record_board.errors++;
    end
    if (record_board.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== pixel_rle_encoder.f =====
rtl/rle_pkg.sv
rtl/rle_core.sv
rtl/rle_queue.sv
rtl/pixel_rle_encoder.sv
rtl/rle_checker.sv
dv/tb_top.sv
